/* sv/grid_min_start_health_dp_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for grid_min_start_health_dp
// Clocked, reset-gated property wrappers used by grid_min_start_health_dp.sv.
// ---------------------------------------------------------------------------
`ifndef GRID_MIN_START_HEALTH_DP_DEFINES_SVH
`define GRID_MIN_START_HEALTH_DP_DEFINES_SVH

// same-cycle implication
`define GMSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gmsh_pkg.sv */
// ---------------------------------------------------------------------------
// gmsh_pkg
// Types and constants shared by the grid minimum-start-health DP block.
// ---------------------------------------------------------------------------
`default_nettype none

package gmsh_pkg;

  localparam int CFG_W       = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int VALUE_W     = 16;
  localparam int NEED_W      = 31;

  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 2'd1;

  localparam logic [NEED_W-1:0] NEED_TOP = {NEED_W{1'b1}};
  localparam logic [NEED_W-1:0] NEED_ONE = NEED_W'(1);

  typedef struct packed {
    logic [NEED_W-1:0] need;
    logic              is_answer;
  } result_t;

endpackage

`default_nettype wire

/* sv/gmsh_cell.sv */
// ---------------------------------------------------------------------------
// gmsh_cell
// One stage of the row-below chain: holds one need, shifts toward the head.
// ---------------------------------------------------------------------------
`default_nettype none

module gmsh_cell
  import gmsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              advance,
  input  wire logic              load_new,
  input  wire logic [NEED_W-1:0] new_need,
  input  wire logic [NEED_W-1:0] chain_need,
  output logic      [NEED_W-1:0] need_q
);

  always_ff @(posedge clk) begin
    if (advance) begin
      need_q <= load_new ? new_need : chain_need;
    end
  end

endmodule

`default_nettype wire

/* sv/gmsh_row_chain.sv */
// ---------------------------------------------------------------------------
// gmsh_row_chain
// Row of cells acting as a delay line as long as the grid is wide: a need
// enters at the tail cell and leaves the head one row later.
// ---------------------------------------------------------------------------
`default_nettype none

module gmsh_row_chain
  import gmsh_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire logic              clk,
  input  wire logic              advance,
  input  wire logic [COL_W-1:0]  tail,
  input  wire logic [NEED_W-1:0] new_need,
  output logic      [NEED_W-1:0] head_need
);

  logic [NEED_W-1:0] cell_q [MAX_COLS];

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    logic [NEED_W-1:0] chain_in;

    if (i == MAX_COLS - 1) begin : g_last
      assign chain_in = new_need;
    end else begin : g_mid
      assign chain_in = cell_q[i+1];
    end

    gmsh_cell u_cell (
      .clk        (clk),
      .advance    (advance),
      .load_new   (tail == COL_W'(i)),
      .new_need   (new_need),
      .chain_need (chain_in),
      .need_q     (cell_q[i])
    );
  end

  assign head_need = cell_q[0];

endmodule

`default_nettype wire

/* sv/gmsh_out_skid.sv */
// ---------------------------------------------------------------------------
// gmsh_out_skid
// Output register with one skid entry; stall toward the core is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module gmsh_out_skid
  import gmsh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  result_t skid_data;
  logic    skid_valid;
  logic    take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (!out_valid) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

/* sv/grid_min_start_health_dp.sv */
// ---------------------------------------------------------------------------
// grid_min_start_health_dp
// Bottom-up minimum starting health over a grid, one cell per request.
// ---------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   config    in         cfg_write             cfg_index, cfg_data
//   cell      in         in_valid / in_stall   cell_value
//   result    out        out_valid / out_stall need_health, is_answer
//
// One cell per cycle while in_stall is low; each result is registered into
// the output (or skid entry if held). The min/subtract/clamp of a cell uses
// the previous cell's need directly, so that path sets the clock. No clearing
// pass after reset. in_stall rises only when the output register and its skid
// entry are full. A size write restarts the grid at the bottom-right cell.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_min_start_health_dp
  import gmsh_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [VALUE_W-1:0] cell_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [NEED_W-1:0]             need_health,
  output logic                          is_answer
);

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CEW    = $clog2(MAX_COLS + 1);
  localparam int REW    = $clog2(MAX_ROWS + 1);
  localparam int CSW    = ((CEW > CFG_W) ? CEW : CFG_W) + 1;
  localparam int RSW    = ((REW > CFG_W) ? REW : CFG_W) + 1;
  localparam int DIFF_W = NEED_W + 2;

  logic [CFG_W-1:0]  grid_rows;
  logic [CFG_W-1:0]  grid_cols;
  logic [NEED_W-1:0] right_need;
  logic [ROW_W-1:0]  row_position;
  logic [COL_W-1:0]  col_position;

  logic [CSW-1:0]    cols_eff;
  logic [RSW-1:0]    rows_eff;
  logic              accept;
  logic              last_col;
  logic              last_row;
  logic [NEED_W-1:0] below_need;
  logic [NEED_W-1:0] min_need;
  logic signed [DIFF_W-1:0] diff;
  logic [NEED_W-1:0] need;
  result_t           result_in;
  result_t           result_out;

  // clamp sizes: zero counts as one, oversize as the maximum
  always_comb begin
    if (grid_cols == '0) begin
      cols_eff = CSW'(1);
    end else if (CSW'(grid_cols) > CSW'(MAX_COLS)) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(grid_cols);
    end
    if (grid_rows == '0) begin
      rows_eff = RSW'(1);
    end else if (RSW'(grid_rows) > RSW'(MAX_ROWS)) begin
      rows_eff = RSW'(MAX_ROWS);
    end else begin
      rows_eff = RSW'(grid_rows);
    end
  end

  assign accept   = in_valid && !in_stall;
  assign last_col = (CSW'(col_position) + CSW'(1)) >= cols_eff;
  assign last_row = (RSW'(row_position) + RSW'(1)) >= rows_eff;

  always_comb begin
    if (row_position == '0 && col_position == '0) begin
      min_need = NEED_ONE;
    end else if (row_position == '0) begin
      min_need = right_need;
    end else if (col_position == '0) begin
      min_need = below_need;
    end else begin
      min_need = (right_need < below_need) ? right_need : below_need;
    end
  end

  assign diff = DIFF_W'(min_need) - DIFF_W'(cell_value);

  always_comb begin
    if (diff < DIFF_W'(1)) begin
      need = NEED_ONE;
    end else if (diff > DIFF_W'(NEED_TOP)) begin
      need = NEED_TOP;
    end else begin
      need = diff[NEED_W-1:0];
    end
  end

  gmsh_row_chain #(
    .MAX_COLS (MAX_COLS)
  ) u_row_chain (
    .clk       (clk),
    .advance   (accept),
    .tail      (COL_W'(cols_eff - CSW'(1))),
    .new_need  (need),
    .head_need (below_need)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= CFG_W'(1);
      grid_cols    <= CFG_W'(1);
      right_need   <= '0;
      row_position <= '0;
      col_position <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_ROWS: begin
          grid_rows    <= cfg_data;
          right_need   <= '0;
          row_position <= '0;
          col_position <= '0;
        end
        REG_GRID_COLS: begin
          grid_cols    <= cfg_data;
          right_need   <= '0;
          row_position <= '0;
          col_position <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (last_col) begin
        // wrap to the right edge of the next row up, or to the bottom row after the last
        col_position <= '0;
        right_need   <= '0;
        row_position <= last_row ? '0 : row_position + ROW_W'(1);
      end else begin
        col_position <= col_position + COL_W'(1);
        right_need   <= need;
      end
    end
  end

  assign result_in.need      = need;
  assign result_in.is_answer = last_col && last_row;

  gmsh_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result_in),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (result_out)
  );

  assign need_health = result_out.need;
  assign is_answer   = result_out.is_answer;

`include "grid_min_start_health_dp_defines.svh"

  `GMSH_ASSERT_NOW(a_skid_implies_out, in_stall, out_valid, "skid full with empty output")
  `GMSH_ASSERT_NOW(a_need_nonzero, out_valid, need_health != '0, "zero need delivered")
  `GMSH_ASSERT_NOW(a_col_in_range, 1'b1, CSW'(col_position) < cols_eff, "column past width")
  `GMSH_ASSERT_NEXT(a_col_step, accept && !cfg_write && !last_col,
                    col_position == $past(col_position) + COL_W'(1), "column did not advance")

endmodule

`default_nettype wire

/* tb/grid_min_start_health_dp_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// grid_min_start_health_dp_tb
// Self-checking bench for the grid minimum-start-health block. Cells are fed
// in reverse raster order over a range of grid sizes, with random gaps on the
// request side and random stalls on the result side. A shadow copy of the row
// store and position counters predicts every need; results are checked in
// order as they are taken.
// ---------------------------------------------------------------------------

module grid_min_start_health_dp_tb;
  import gmsh_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int GRID_MAX_COLS = DEF_MAX_COLS;
  localparam int GRID_MAX_ROWS = DEF_MAX_ROWS;
  localparam int RANDOM_CELLS  = 110;
  localparam int HOLD_CYCLES   = 40;
  localparam int IDLE_TAIL     = 4;
  localparam int MAX_REPORTS   = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] cell_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [NEED_W-1:0]         need_health;
  logic                      is_answer;

  // shadow of the block's registers and grid state
  logic [CFG_W-1:0]  shadow_rows;
  logic [CFG_W-1:0]  shadow_cols;
  logic [NEED_W-1:0] below_need [GRID_MAX_COLS];
  logic [NEED_W-1:0] right_need_val;
  int                row_at;
  int                col_at;

  result_t expected_needs[$];
  int      mismatch_count;
  int      cells_sent;
  bit      no_idle;
  bit      hold_pending;
  int      hold_count;

  grid_min_start_health_dp dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cell_value  (cell_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .need_health (need_health),
    .is_answer   (is_answer)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(64'd20_000_000);
    $display("** grid_min_start_health_dp: FAILED **");
    $finish;
  end

  function automatic int eff_size(input logic [CFG_W-1:0] val, input int top);
    if (val == '0) return 1;
    if (int'(val) > top) return top;
    return int'(val);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    int small_val;
    r = $urandom_range(0, 99);
    small_val = int'($urandom_range(0, 24)) - 12;
    if (r < 50) return VALUE_W'(small_val);
    if (r < 85) return VALUE_W'($urandom);
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'shffff;
      3: return 16'sh0001;
      default: return 16'sh0000;
    endcase
  endfunction

  function automatic void reset_shadow();
    shadow_rows    = 9'd1;
    shadow_cols    = 9'd1;
    right_need_val = '0;
    row_at         = 0;
    col_at         = 0;
    foreach (below_need[i]) below_need[i] = '0;
  endfunction

  // work out the need of one cell and advance the grid position
  function automatic void predict_cell(input logic signed [VALUE_W-1:0] v);
    int      rows_eff;
    int      cols_eff;
    longint  best;
    longint  need;
    bit      have;
    bit      last_col;
    bit      last_row;
    result_t res;
    rows_eff = eff_size(shadow_rows, GRID_MAX_ROWS);
    cols_eff = eff_size(shadow_cols, GRID_MAX_COLS);
    have = 1'b0;
    best = 0;
    if (row_at != 0) begin
      best = longint'(below_need[col_at]);
      have = 1'b1;
    end
    if (col_at != 0) begin
      if (!have || longint'(right_need_val) < best) best = longint'(right_need_val);
      have = 1'b1;
    end
    // bottom-right cell has no neighbour
    if (!have) best = 1;
    need = best - longint'(v);
    if (need < 1) need = 1;
    if (need > longint'(NEED_TOP)) need = longint'(NEED_TOP);
    below_need[col_at] = need[NEED_W-1:0];
    right_need_val     = need[NEED_W-1:0];
    last_col = (col_at + 1 >= cols_eff);
    last_row = (row_at + 1 >= rows_eff);
    res.need      = need[NEED_W-1:0];
    res.is_answer = last_col && last_row;
    expected_needs.push_back(res);
    if (last_col) begin
      col_at = 0;
      right_need_val = '0;
      if (last_row) row_at = 0;
      else row_at++;
    end else begin
      col_at++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_GRID_ROWS || idx == REG_GRID_COLS) begin
      if (idx == REG_GRID_ROWS) shadow_rows = val;
      else shadow_cols = val;
      // any size write restarts the grid
      right_need_val = '0;
      row_at = 0;
      col_at = 0;
    end
  endtask

  task automatic send_cell(input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cell_value <= v;
    do @(posedge clk); while (in_stall);
    predict_cell(v);
    cells_sent++;
  endtask

  // drop valid and wait until every pending result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_needs.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: need exp %0d got %0d, answer exp %0b got %0b", $realtime, what,
               want.need, got.need, want.is_answer, got.is_answer);
  endtask

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.need      = need_health;
      got.is_answer = is_answer;
      if (expected_needs.size() == 0) begin
        want = '0;
        flag_mismatch("result with no request pending", want, got);
      end else begin
        want = expected_needs.pop_front();
        if (got.need !== want.need || got.is_answer !== want.is_answer)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic test_reset_defaults();
    settle();
    send_cell(16'sh7fff);
    send_cell(16'sh8000);
    send_cell(16'sh0000);
  endtask

  task automatic test_zero_size();
    settle();
    write_reg(REG_GRID_ROWS, 9'd0);
    write_reg(REG_GRID_COLS, 9'd0);
    send_cell(-16'sd5);
  endtask

  task automatic test_small_grid();
    settle();
    write_reg(REG_GRID_ROWS, 9'd2);
    write_reg(REG_GRID_COLS, 9'd3);
    send_cell(16'sh8000);
    send_cell(16'sh7fff);
    send_cell(-16'sd1);
    send_cell(16'sd0);
    send_cell(16'sd1);
    send_cell(-16'sd5);
  endtask

  task automatic test_restart_mid_grid();
    settle();
    write_reg(REG_GRID_ROWS, 9'd2);
    write_reg(REG_GRID_COLS, 9'd2);
    send_cell(-16'sd3);
    send_cell(-16'sd7);
    settle();
    write_reg(REG_GRID_COLS, 9'd2);
    repeat (4) send_cell(pick_value());
  endtask

  task automatic test_unknown_index();
    settle();
    write_reg(REG_GRID_ROWS, 9'd2);
    write_reg(REG_GRID_COLS, 9'd2);
    send_cell(-16'sd10);
    send_cell(16'sd4);
    settle();
    // must not restart the grid
    write_reg(REG_SPARE_2, 9'h1ff);
    write_reg(REG_SPARE_3, 9'h0aa);
    send_cell(-16'sd2);
    send_cell(16'sh8000);
  endtask

  task automatic test_oversize_sizes();
    settle();
    write_reg(REG_GRID_ROWS, 9'h1ff);
    write_reg(REG_GRID_COLS, 9'd300);
    repeat (3) send_cell(pick_value());
    settle();
    write_reg(REG_GRID_ROWS, 9'd1);
    write_reg(REG_GRID_COLS, 9'd2);
    send_cell(-16'sd9);
    send_cell(16'sd3);
  endtask

  task automatic test_result_hold();
    settle();
    write_reg(REG_GRID_ROWS, 9'd4);
    write_reg(REG_GRID_COLS, 9'd5);
    no_idle = 1'b1;
    hold_pending = 1'b1;
    repeat (20) send_cell(pick_value());
    settle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_grids();
    int start;
    int r;
    int rows_eff;
    int cols_eff;
    int cells;
    logic [CFG_W-1:0] rows_val;
    logic [CFG_W-1:0] cols_val;
    start = cells_sent;
    while (cells_sent < start + RANDOM_CELLS) begin
      settle();
      no_idle = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      rows_val = (r < 4) ? 9'd0 : (r < 8) ? CFG_W'($urandom_range(257, 511))
                                          : CFG_W'($urandom_range(1, 6));
      r = $urandom_range(0, 99);
      cols_val = (r < 4) ? 9'd0 : (r < 8) ? CFG_W'($urandom_range(257, 511))
                                          : CFG_W'($urandom_range(1, 8));
      if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_ROWS, rows_val);
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
      if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_COLS, cols_val);
      rows_eff = eff_size(shadow_rows, GRID_MAX_ROWS);
      cols_eff = eff_size(shadow_cols, GRID_MAX_COLS);
      // keep huge grids partial
      if (rows_eff * cols_eff > 64) cells = $urandom_range(1, 40);
      else if ($urandom_range(0, 99) < 80) cells = rows_eff * cols_eff * $urandom_range(1, 2);
      else cells = $urandom_range(1, rows_eff * cols_eff);
      repeat (cells) send_cell(pick_value());
    end
    settle();
    no_idle = 1'b0;
  endtask

  task automatic test_widest_row();
    settle();
    write_reg(REG_GRID_ROWS, 9'd2);
    write_reg(REG_GRID_COLS, 9'd256);
    repeat (GRID_MAX_COLS + 8) send_cell(pick_value());
  endtask

  initial begin
    mismatch_count = 0;
    cells_sent     = 0;
    no_idle        = 1'b0;
    hold_pending   = 1'b0;
    hold_count     = 0;
    reset_shadow();
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_GRID_ROWS;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    cell_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_size();
    test_small_grid();
    test_restart_mid_grid();
    test_unknown_index();
    test_oversize_sizes();
    test_result_hold();
    test_random_grids();
    test_widest_row();
    settle();

    if (mismatch_count == 0 && expected_needs.size() == 0)
      $display("** grid_min_start_health_dp: PASSED **");
    else
      $display("** grid_min_start_health_dp: FAILED **");
    $finish;
  end

endmodule
